// ----- hdl/htok_pkg.sv -----
// ----------------------------------------------------------------------------
// htok_pkg
// Shared types and constants of the request head tokenizer.
// ----------------------------------------------------------------------------
package htok_pkg;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;

  localparam logic [2:0] CLS_METHOD  = 3'd0;
  localparam logic [2:0] CLS_URL     = 3'd1;
  localparam logic [2:0] CLS_VERSION = 3'd2;
  localparam logic [2:0] CLS_KEY     = 3'd3;
  localparam logic [2:0] CLS_VALUE   = 3'd4;
  localparam logic [2:0] CLS_DELIM   = 3'd5;

  typedef struct packed {
    logic [7:0] data;
    logic [2:0] cls;
    logic       line_end;
    logic       header_ok;
    logic       is_get;
    logic       head_done;
    logic       error_code;
  } res_t;

  // one entry holds one or two results; an accepted byte gives none, one or two
  typedef struct packed {
    res_t r0;
    res_t r1;
    logic two;
  } ent_t;

  function automatic res_t mk_res(logic [7:0] data, logic [2:0] cls, logic le,
                                  logic ok, logic get, logic done, logic err);
    res_t r;
    r.data       = data;
    r.cls        = cls;
    r.line_end   = le;
    r.header_ok  = ok;
    r.is_get     = get;
    r.head_done  = done;
    r.error_code = err;
    return r;
  endfunction

endpackage

// ----- hdl/htok_front.sv -----
// ----------------------------------------------------------------------------
// htok_front
// Parses one byte per cycle while accept is high, tracks line state and builds result entries.
// ----------------------------------------------------------------------------
module htok_front
  import htok_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] in_byte,
  output logic       ent_valid,
  output ent_t       ent
);

  typedef enum logic [2:0] {
    PH_METHOD  = 3'd0,
    PH_URL     = 3'd1,
    PH_VERSION = 3'd2,
    PH_KEY     = 3'd3,
    PH_VALUE   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    HELD_NONE  = 2'd0,
    HELD_CR    = 2'd1,
    HELD_COLON = 2'd2
  } held_t;

  localparam logic [2:0] GMP_MATCH = 3'd3;
  localparam logic [2:0] GMP_FAIL  = 3'd4;

  phase_t     phase_r, phase_nxt;
  held_t      held_r, held_nxt;
  logic       lhb_r, lhb_nxt;
  logic       kne_r, kne_nxt;
  logic       vne_r, vne_nxt;
  logic [2:0] gmp_r, gmp_nxt;

  logic [1:0] n;
  logic       pre_en;
  logic [7:0] pre_b;
  logic       do_proc;
  res_t       r0, r1, rnew;

  function automatic logic [7:0] get_char(logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h47;
      2'd1:    c = 8'h45;
      default: c = 8'h54;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] gmp_next(logic [2:0] g, logic [7:0] b);
    logic [7:0] up;
    up = (b >= 8'h61 && b <= 8'h7A) ? b - 8'd32 : b;
    if (g < GMP_MATCH && up == get_char(g[1:0])) begin
      return g + 3'd1;
    end
    return GMP_FAIL;
  endfunction

  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = HELD_NONE;
    lhb_nxt   = lhb_r;
    kne_nxt   = kne_r;
    vne_nxt   = vne_r;
    gmp_nxt   = gmp_r;
    n         = 2'd0;
    r0        = '0;
    r1        = '0;
    rnew      = '0;
    pre_en    = 1'b0;
    pre_b     = CH_CR;
    do_proc   = 1'b0;

    if (held_r == HELD_CR) begin
      if (in_byte == CH_LF) begin
        r0 = mk_res(CH_CR, CLS_DELIM, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        n  = 2'd2;
        if (phase_r == PH_METHOD && !lhb_r) begin
          r1 = mk_res(CH_LF, CLS_DELIM, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        end else begin
          lhb_nxt = 1'b0;
          kne_nxt = 1'b0;
          vne_nxt = 1'b0;
          if (phase_r == PH_KEY) begin
            r1 = mk_res(CH_LF, CLS_DELIM, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);
            phase_nxt = PH_METHOD;
            gmp_nxt   = '0;
          end else if (phase_r == PH_VALUE) begin
            r1 = mk_res(CH_LF, CLS_DELIM, 1'b1, kne_r & vne_r, 1'b0, 1'b0, 1'b0);
            phase_nxt = PH_KEY;
          end else begin
            r1 = mk_res(CH_LF, CLS_DELIM, 1'b1, 1'b0, gmp_r == GMP_MATCH, 1'b0,
                        phase_r != PH_VERSION);
            phase_nxt = PH_KEY;
          end
        end
      end else begin
        pre_en  = 1'b1;
        pre_b   = CH_CR;
        do_proc = 1'b1;
      end
    end else if (held_r == HELD_COLON) begin
      if (in_byte == CH_SP && phase_r == PH_KEY) begin
        r0 = mk_res(CH_COLON, CLS_DELIM, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        r1 = mk_res(CH_SP, CLS_DELIM, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        n  = 2'd2;
        phase_nxt = PH_VALUE;
      end else begin
        pre_en  = 1'b1;
        pre_b   = CH_COLON;
        do_proc = 1'b1;
      end
    end else begin
      do_proc = 1'b1;
    end

    // held byte turns into a field byte
    if (pre_en) begin
      if (phase_nxt == PH_METHOD) begin
        gmp_nxt = gmp_next(gmp_nxt, pre_b);
      end else if (phase_nxt == PH_KEY) begin
        kne_nxt = 1'b1;
      end else if (phase_nxt == PH_VALUE) begin
        vne_nxt = 1'b1;
      end
      lhb_nxt = 1'b1;
      r0 = mk_res(pre_b, 3'(phase_nxt), 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      n  = 2'd1;
    end

    if (do_proc) begin
      if (in_byte == CH_CR) begin
        held_nxt = HELD_CR;
      end else if ((phase_nxt == PH_METHOD || phase_nxt == PH_URL) && in_byte == CH_SP) begin
        lhb_nxt   = 1'b1;
        rnew      = mk_res(CH_SP, CLS_DELIM, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        n         = n + 2'd1;
        phase_nxt = (phase_nxt == PH_METHOD) ? PH_URL : PH_VERSION;
      end else if (phase_nxt == PH_KEY && in_byte == CH_COLON) begin
        held_nxt = HELD_COLON;
        lhb_nxt  = 1'b1;
      end else begin
        if (phase_nxt == PH_METHOD) begin
          gmp_nxt = gmp_next(gmp_nxt, in_byte);
        end else if (phase_nxt == PH_KEY) begin
          kne_nxt = 1'b1;
        end else if (phase_nxt == PH_VALUE) begin
          vne_nxt = 1'b1;
        end
        lhb_nxt = 1'b1;
        rnew    = mk_res(in_byte, 3'(phase_nxt), 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        n       = n + 2'd1;
      end
      if (pre_en) begin
        r1 = rnew;
      end else begin
        r0 = rnew;
      end
    end
  end

  assign ent_valid = accept && (n != 2'd0);
  assign ent.r0    = r0;
  assign ent.r1    = r1;
  assign ent.two   = n[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_METHOD;
      held_r  <= HELD_NONE;
      lhb_r   <= 1'b0;
      kne_r   <= 1'b0;
      vne_r   <= 1'b0;
      gmp_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      lhb_r   <= lhb_nxt;
      kne_r   <= kne_nxt;
      vne_r   <= vne_nxt;
      gmp_r   <= gmp_nxt;
    end
  end

endmodule

// ----- hdl/htok_fifo.sv -----
// ----------------------------------------------------------------------------
// htok_fifo
// Short queue of result entries between front and back.
// ----------------------------------------------------------------------------
module htok_fifo
  import htok_pkg::*;
#(
  parameter int DEPTH = 4
)(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  ent_t wr_data,
  input  logic rd_en,
  output ent_t rd_data,
  output logic fifo_full,
  output logic fifo_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ent_t            mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_wr, do_rd;

  assign fifo_full  = (cnt_r == CW'(DEPTH));
  assign fifo_empty = (cnt_r == '0);
  assign do_wr      = wr_en && !fifo_full;
  assign do_rd      = rd_en && !fifo_empty;
  assign rd_data    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ----- hdl/htok_back.sv -----
// ----------------------------------------------------------------------------
// htok_back
// Splits queued entries into single results and holds the output register.
// ----------------------------------------------------------------------------
module htok_back
  import htok_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  ent_t head,
  input  logic head_empty,
  output logic head_pop,
  input  logic pop,
  output logic empty,
  output res_t res,
  output logic res_last
);

  res_t res_r, res_nxt;
  logic last_r, last_nxt;
  logic valid_r, valid_nxt;
  logic sub_r, sub_nxt;
  logic load, take;

  assign load = !valid_r || pop;
  assign take = load && !head_empty;

  always_comb begin
    res_nxt   = res_r;
    last_nxt  = last_r;
    valid_nxt = valid_r && !pop;
    sub_nxt   = sub_r;
    head_pop  = 1'b0;
    if (take) begin
      valid_nxt = 1'b1;
      if (head.two && !sub_r) begin
        res_nxt  = head.r0;
        last_nxt = 1'b0;
        sub_nxt  = 1'b1;
      end else begin
        res_nxt  = sub_r ? head.r1 : head.r0;
        last_nxt = 1'b1;
        sub_nxt  = 1'b0;
        head_pop = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r  <= res_nxt;
    last_r <= last_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
      sub_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      sub_r   <= sub_nxt;
    end
  end

  assign empty    = !valid_r;
  assign res      = res_r;
  assign res_last = last_r;

endmodule

// ----- hdl/http_request_head_tokenizer_core.sv -----
// path: an accepted byte's results are written to the entry queue, then loaded into the output register
// throughput: one byte per cycle while full is low; a byte with two results holds the output for two pops
// the output pop rate sets the pace, the entry queue absorbs short stalls
// reset: synchronous active-low rst_n clears parser state, queue pointers and the valid flag of the output register
// ----------------------------------------------------------------------------
// http_request_head_tokenizer_core
// Tags each byte of an HTTP request head with its field and line events.
// ----------------------------------------------------------------------------
module http_request_head_tokenizer_core
  import htok_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
)(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic [2:0] out_field_class,
  output logic       out_line_end,
  output logic       out_header_ok,
  output logic       out_is_get,
  output logic       out_head_done,
  output logic       out_error_code,
  output logic       out_last
);

  logic accept;
  logic ent_valid;
  ent_t ent;
  ent_t head;
  logic head_empty;
  logic head_pop;
  res_t res;

  assign accept = push && !full;

  htok_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_byte   (in_byte),
    .ent_valid (ent_valid),
    .ent       (ent)
  );

  htok_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (ent_valid),
    .wr_data    (ent),
    .rd_en      (head_pop),
    .rd_data    (head),
    .fifo_full  (full),
    .fifo_empty (head_empty)
  );

  htok_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_empty (head_empty),
    .head_pop   (head_pop),
    .pop        (pop),
    .empty      (empty),
    .res        (res),
    .res_last   (out_last)
  );

  assign out_byte        = res.data;
  assign out_field_class = res.cls;
  assign out_line_end    = res.line_end;
  assign out_header_ok   = res.header_ok;
  assign out_is_get      = res.is_get;
  assign out_head_done   = res.head_done;
  assign out_error_code  = res.error_code;

endmodule
